// ===== hw/rtl/sfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Structure factor accumulator package
// Shared widths, constants, enums and structs of the accumulator.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int KD_W    = 3;
  localparam int ADDR_W  = 3 * KD_W;
  localparam int NVEC    = 1 << ADDR_W;
  localparam int POS_W   = 16;
  localparam int QB      = 14;
  localparam int QS_W    = QB + 1;
  localparam int SUM_W   = 27;
  localparam int PWR_W   = 48;
  localparam int SF_W    = 24;
  localparam int SMP_W   = 12;
  localparam int PCNT_W  = 11;
  localparam int SNAP_W  = 16;
  localparam int MAXP    = 1024;
  localparam int QS_LAT  = 7;
  localparam int DIV_W   = SMP_W + PCNT_W;
  localparam int IT_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598669;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KBOUND = 2'd0,
    CFG_DKMULT = 2'd1,
    CFG_EQUIL  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_POS  = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PART,
    ST_DRAIN_P,
    ST_CLOSE,
    ST_DRAIN_C,
    ST_RD,
    ST_RD_WAIT,
    ST_DIV,
    ST_RES
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic              last;
    logic [KD_W-1:0]   qx;
    logic [KD_W-1:0]   qy;
    logic [KD_W-1:0]   qz;
  } item_t;

  typedef struct packed {
    logic [KD_W-1:0]   k_bound;
    logic [3:0]        dk_mult;
    logic [SNAP_W-1:0] equil;
  } cfg_t;

endpackage

// ===== hw/rtl/sfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sfa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator front end
// Holds the configuration registers and queues incoming transactions.
// ----------------------------------------------------------------------------
module sfa_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [sfa_pkg::POS_W-1:0]      in_pos_x,
  input  logic [sfa_pkg::POS_W-1:0]      in_pos_y,
  input  logic [sfa_pkg::POS_W-1:0]      in_pos_z,
  input  logic                           in_last_particle,
  input  logic [sfa_pkg::KD_W-1:0]       in_query_nx,
  input  logic [sfa_pkg::KD_W-1:0]       in_query_ny,
  input  logic [sfa_pkg::KD_W-1:0]       in_query_nz,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           clearing,
  input  logic                           item_pop,
  output logic                           item_valid,
  output sfa_pkg::item_t                 item,
  output sfa_pkg::cfg_t                  cfg
);

  import sfa_pkg::*;

  cfg_t       cfg_r;
  item_t      q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] count_r;
  logic       push;
  item_t      in_item;

  assign cfg_ready  = 1'b1;
  assign cfg        = cfg_r;
  assign in_ready   = (count_r != 2'd2) && !clearing;
  assign push       = in_valid && in_ready;
  assign item_valid = (count_r != 2'd0);
  assign item       = q_r[rp_r];

  always_comb begin
    in_item.kind = in_func ? KIND_READ : KIND_POS;
    in_item.x    = in_pos_x;
    in_item.y    = in_pos_y;
    in_item.z    = in_pos_z;
    in_item.last = in_last_particle;
    in_item.qx   = in_query_nx;
    in_item.qy   = in_query_ny;
    in_item.qz   = in_query_nz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k_bound <= KD_W'(3);
      cfg_r.dk_mult <= 4'd1;
      cfg_r.equil   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KBOUND: cfg_r.k_bound <= cfg_data[KD_W-1:0];
        CFG_DKMULT: cfg_r.dk_mult <= cfg_data[3:0];
        CFG_EQUIL:  cfg_r.equil   <= cfg_data[SNAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (item_pop) begin
        rp_r <= ~rp_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, item_pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'd2)
    else $error("Queue count out of range.");

endmodule

// ===== hw/rtl/sfa_qsine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine pipeline
// Evaluates the odd polynomial sine of a quarter-turn offset in Q15.
// ----------------------------------------------------------------------------
module sfa_qsine (
  input  logic                     clk,
  input  logic [sfa_pkg::QS_W-1:0] r,
  output logic [14:0]              s_q15
);

  import sfa_pkg::*;

  function automatic logic [30:0] horner(input logic [30:0] c, input logic [30:0] p,
                                         input logic [30:0] u2);
    logic [61:0] prod;
    logic [31:0] t;
    prod = {31'd0, p} * {31'd0, u2};
    t = {1'b0, c} - prod[61:30];
    return t[30:0];
  endfunction

  logic [QS_W-1:0] r_a, r_b, r_c, r_d, r_e;
  logic [30:0]     u2_a, u2_b, u2_c, u2_d;
  logic [30:0]     p_b, p_c, p_d, p_e;
  logic [31:0]     s_f;
  logic [29:0]     sq;
  logic [45:0]     fp;
  logic [32:0]     rnd;

  assign sq  = {15'd0, r} * {15'd0, r};
  assign fp  = {15'd0, p_e} * {31'd0, r_e};
  assign rnd = {1'b0, s_f} + 33'(1 << 14);

  always_ff @(posedge clk) begin
    r_a   <= r;
    u2_a  <= {sq[28:0], 2'b00};
    r_b   <= r_a;
    u2_b  <= u2_a;
    p_b   <= horner(C7, C9, u2_a);
    r_c   <= r_b;
    u2_c  <= u2_b;
    p_c   <= horner(C5, p_b, u2_b);
    r_d   <= r_c;
    u2_d  <= u2_c;
    p_d   <= horner(C3, p_c, u2_c);
    r_e   <= r_d;
    p_e   <= horner(C1, p_d, u2_d);
    s_f   <= fp[45:14];
    s_q15 <= (|rnd[32:30]) ? 15'h7FFF : rnd[29:15];
  end

endmodule

// ===== hw/rtl/sfa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator back end
// Sweeps the wave-vector sums per particle, folds them into the power store
// at the end of a snapshot and answers read transactions.
// ----------------------------------------------------------------------------
module sfa_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfa_pkg::cfg_t             cfg,
  input  sfa_pkg::item_t            item,
  input  logic                      item_valid,
  output logic                      item_pop,
  output logic                      clearing,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [sfa_pkg::SF_W-1:0]  out_s_factor,
  output logic [sfa_pkg::PWR_W-1:0] out_power_total,
  output logic [sfa_pkg::SMP_W-1:0] out_sample_total,
  output logic                      out_no_samples,
  output logic                      out_index_invalid
);

  import sfa_pkg::*;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic              cnt_last;
  item_t             item_r;
  logic [SNAP_W-1:0] snap_r;
  logic [SMP_W-1:0]  smp_r;
  logic [PCNT_W-1:0] particles_r;
  logic [PCNT_W-1:0] size_r;
  logic              sampled_r;
  logic              clr_r;

  logic part_issue, sweep_issue, start_close, load_out, accept_pos, pipe_busy, div_done;

  logic              s1_v_r, s1_inb_r;
  logic [ADDR_W-1:0] s1_a_r;
  logic [POS_W-1:0]  s1_dot_r;
  logic              dv_r  [QS_LAT+1];
  logic              dinb_r[QS_LAT+1];
  logic [1:0]        dq_r  [QS_LAT+1];
  logic [ADDR_W-1:0] da_r  [QS_LAT+1];
  logic [QS_W-1:0]   r_r, rc_r;
  logic [14:0]       sr_q, sc_q;

  logic              cv1_r, cv2_r;
  logic [ADDR_W-1:0] ca1_r, ca2_r;
  logic [52:0]       csq_r, ssq_r;
  logic [PWR_W-1:0]  pw2_r;

  logic [DIV_W-1:0]  div_r, rem_r;
  logic [PWR_W-1:0]  dvd_r, pwr_r;
  logic              inv_r;
  logic [IT_W-1:0]   it_r;

  logic [KD_W-1:0]   nx, ny, nz;
  logic [18:0]       px, py, pz;
  logic [POS_W-1:0]  dot;
  logic [19:0]       ph;
  logic              inb;

  logic [SUM_W-1:0]  cos_rd, sin_rd, cos_wd, sin_wd, cos_acc, sin_acc, cval, sval;
  logic [ADDR_W-1:0] cs_raddr, cs_waddr, pw_raddr;
  logic              cs_we, pw_we, part_we;
  logic [PWR_W-1:0]  pw_rd, pw_wd, pw_sat;
  logic [53:0]       c_prod, s_prod, sq_sum;
  logic [48:0]       pw_tot;
  logic [DIV_W:0]    trial;
  logic              qbit;
  logic [DIV_W-1:0]  rem_nxt;
  logic [SF_W-1:0]   sf;
  logic              inv_q;
  logic [DIV_W-1:0]  div_prod;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] t;
    t = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

  assign cnt_last = (cnt_r == ADDR_W'(NVEC - 1));
  assign clearing = (state_r == ST_CLEAR);
  assign div_done = (it_r == IT_W'(PWR_W - 1));

  always_comb begin
    pipe_busy = s1_v_r | cv1_r | cv2_r;
    for (int i = 0; i <= QS_LAT; i++) begin
      pipe_busy = pipe_busy | dv_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    item_pop    = 1'b0;
    part_issue  = 1'b0;
    sweep_issue = 1'b0;
    start_close = 1'b0;
    load_out    = 1'b0;
    accept_pos  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        sweep_issue = 1'b1;
        if (cnt_last) state_nxt = ST_DRAIN_C;
      end
      ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (item.kind == KIND_READ) begin
            state_nxt = ST_RD;
          end else if (particles_r < PCNT_W'(MAXP)) begin
            accept_pos = 1'b1;
            state_nxt  = ST_PART;
          end else if (item.last) begin
            start_close = 1'b1;
            state_nxt   = ST_CLOSE;
          end
        end
      end
      ST_PART: begin
        part_issue = 1'b1;
        if (cnt_last) state_nxt = ST_DRAIN_P;
      end
      ST_DRAIN_P: begin
        if (!pipe_busy) begin
          if (item_r.last) begin
            start_close = 1'b1;
            state_nxt   = ST_CLOSE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CLOSE: begin
        sweep_issue = 1'b1;
        if (cnt_last) state_nxt = ST_DRAIN_C;
      end
      ST_DRAIN_C: begin
        if (!pipe_busy) state_nxt = ST_IDLE;
      end
      ST_RD:      state_nxt = ST_RD_WAIT;
      ST_RD_WAIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_RES;
      end
      ST_RES: begin
        if (!out_valid || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Snapshot bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      snap_r      <= '0;
      smp_r       <= '0;
      particles_r <= '0;
      size_r      <= '0;
      sampled_r   <= 1'b0;
      clr_r       <= 1'b1;
    end else begin
      if (part_issue || sweep_issue) begin
        cnt_r <= cnt_r + ADDR_W'(1);
      end
      if (accept_pos) begin
        particles_r <= particles_r + PCNT_W'(1);
      end
      if (start_close) begin
        size_r      <= particles_r;
        particles_r <= '0;
        clr_r       <= 1'b0;
        sampled_r   <= (snap_r >= cfg.equil) && (smp_r != {SMP_W{1'b1}});
        if ((snap_r >= cfg.equil) && (smp_r != {SMP_W{1'b1}})) begin
          smp_r <= smp_r + SMP_W'(1);
        end
        if (snap_r != {SNAP_W{1'b1}}) begin
          snap_r <= snap_r + SNAP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      item_r <= item;
    end
  end

  // Phase of the current wave vector.
  assign nx  = cnt_r[ADDR_W-1 -: KD_W];
  assign ny  = cnt_r[2*KD_W-1 -: KD_W];
  assign nz  = cnt_r[KD_W-1:0];
  assign px  = {3'd0, item_r.x} * {16'd0, nx};
  assign py  = {3'd0, item_r.y} * {16'd0, ny};
  assign pz  = {3'd0, item_r.z} * {16'd0, nz};
  assign dot = px[POS_W-1:0] + py[POS_W-1:0] + pz[POS_W-1:0];
  assign inb = (nx <= cfg.k_bound) && (ny <= cfg.k_bound) && (nz <= cfg.k_bound);
  assign ph  = {4'd0, s1_dot_r} * {16'd0, cfg.dk_mult};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      for (int i = 0; i <= QS_LAT; i++) begin
        dv_r[i] <= 1'b0;
      end
      cv1_r <= 1'b0;
      cv2_r <= 1'b0;
    end else begin
      s1_v_r  <= part_issue;
      dv_r[0] <= s1_v_r;
      for (int i = 1; i <= QS_LAT; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
      cv1_r <= sweep_issue;
      cv2_r <= cv1_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r    <= cnt_r;
    s1_inb_r  <= inb;
    s1_dot_r  <= dot;
    da_r[0]   <= s1_a_r;
    dinb_r[0] <= s1_inb_r;
    dq_r[0]   <= ph[POS_W-1:QB];
    r_r       <= {1'b0, ph[QB-1:0]};
    rc_r      <= QS_W'(1 << QB) - {1'b0, ph[QB-1:0]};
    for (int i = 1; i <= QS_LAT; i++) begin
      da_r[i]   <= da_r[i-1];
      dinb_r[i] <= dinb_r[i-1];
      dq_r[i]   <= dq_r[i-1];
    end
  end

  sfa_qsine u_sin_r (
    .clk   (clk),
    .r     (r_r),
    .s_q15 (sr_q)
  );

  sfa_qsine u_sin_rc (
    .clk   (clk),
    .r     (rc_r),
    .s_q15 (sc_q)
  );

  always_comb begin
    case (dq_r[QS_LAT])
      2'd0: begin
        cval = {12'd0, sc_q};
        sval = {12'd0, sr_q};
      end
      2'd1: begin
        cval = SUM_W'(0) - {12'd0, sr_q};
        sval = {12'd0, sc_q};
      end
      2'd2: begin
        cval = SUM_W'(0) - {12'd0, sc_q};
        sval = SUM_W'(0) - {12'd0, sr_q};
      end
      default: begin
        cval = {12'd0, sr_q};
        sval = SUM_W'(0) - {12'd0, sc_q};
      end
    endcase
  end

  assign cos_acc = sat_add(cos_rd, cval);
  assign sin_acc = sat_add(sin_rd, sval);
  assign part_we = dv_r[QS_LAT] && dinb_r[QS_LAT];

  // Snapshot fold: power += (c^2 + s^2) >> 16, saturating.
  assign c_prod = $signed(cos_rd) * $signed(cos_rd);
  assign s_prod = $signed(sin_rd) * $signed(sin_rd);
  assign sq_sum = {1'b0, csq_r} + {1'b0, ssq_r};
  assign pw_tot = {1'b0, pw2_r} + {11'd0, sq_sum[53:16]};
  assign pw_sat = pw_tot[PWR_W] ? {PWR_W{1'b1}} : pw_tot[PWR_W-1:0];

  always_ff @(posedge clk) begin
    ca1_r <= cnt_r;
    ca2_r <= ca1_r;
    csq_r <= c_prod[52:0];
    ssq_r <= s_prod[52:0];
    pw2_r <= pw_rd;
  end

  assign cs_raddr = dv_r[QS_LAT-1] ? da_r[QS_LAT-1] : cnt_r;
  assign cs_we    = part_we || cv2_r;
  assign cs_waddr = cv2_r ? ca2_r : da_r[QS_LAT];
  assign cos_wd   = cv2_r ? '0 : cos_acc;
  assign sin_wd   = cv2_r ? '0 : sin_acc;
  assign pw_raddr = (state_r == ST_RD) ? {item_r.qx, item_r.qy, item_r.qz} : cnt_r;
  assign pw_we    = cv2_r && (sampled_r || clr_r);
  assign pw_wd    = clr_r ? '0 : pw_sat;

  sfa_ram #(.WIDTH(SUM_W), .DEPTH(NVEC)) u_cos_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (cos_wd),
    .raddr (cs_raddr),
    .rdata (cos_rd)
  );

  sfa_ram #(.WIDTH(SUM_W), .DEPTH(NVEC)) u_sin_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (sin_wd),
    .raddr (cs_raddr),
    .rdata (sin_rd)
  );

  sfa_ram #(.WIDTH(PWR_W), .DEPTH(NVEC)) u_pwr_ram (
    .clk   (clk),
    .we    (pw_we),
    .waddr (ca2_r),
    .wdata (pw_wd),
    .raddr (pw_raddr),
    .rdata (pw_rd)
  );

  // Read transactions: restoring division, one quotient bit per cycle.
  assign inv_q    = (item_r.qx > cfg.k_bound) || (item_r.qy > cfg.k_bound) ||
                    (item_r.qz > cfg.k_bound);
  assign div_prod = {PCNT_W'(0), smp_r} * {SMP_W'(0), size_r};
  assign trial    = {rem_r, dvd_r[PWR_W-1]};
  assign qbit     = (trial >= {1'b0, div_r});
  assign rem_nxt  = qbit ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
  assign sf       = (div_r == '0) ? '0 :
                    (|dvd_r[PWR_W-1:SF_W]) ? {SF_W{1'b1}} : dvd_r[SF_W-1:0];

  always_ff @(posedge clk) begin
    case (state_r)
      ST_RD: begin
        div_r <= div_prod;
        inv_r <= inv_q;
      end
      ST_RD_WAIT: begin
        pwr_r <= inv_r ? '0 : pw_rd;
        dvd_r <= inv_r ? '0 : pw_rd;
        rem_r <= '0;
        it_r  <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[PWR_W-2:0], qbit};
        it_r  <= it_r + IT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_s_factor      <= sf;
      out_power_total   <= pwr_r;
      out_sample_total  <= smp_r;
      out_no_samples    <= (smp_r == '0);
      out_index_invalid <= inv_r;
    end
  end

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(part_we && cv2_r))
    else $error("Particle and snapshot sweeps write the sums together.");

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pipe_busy)
    else $error("Idle with work still in the pipeline.");

  a_close_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
    start_close |=> (particles_r == '0))
    else $error("Particle count not cleared at snapshot end.");

  a_no_samples_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_samples) |-> (out_s_factor == '0))
    else $error("Nonzero structure factor without samples.");

endmodule

// ===== hw/rtl/structure_factor_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Structure factor accumulator
// Direct-sum static structure factor over a grid of wave vectors.
// ----------------------------------------------------------------------------
// A position transaction steps through every wave vector, one per cycle,
// through the phase and sine pipeline, and then drains it.
// A closing position takes another sweep of the sum memories.
// A read transaction runs through the bit-serial divider.
// After reset a clearing pass runs before the first transaction;
// configuration writes are taken at any time.
module structure_factor_accumulator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [sfa_pkg::POS_W-1:0]      in_pos_x,
  input  logic [sfa_pkg::POS_W-1:0]      in_pos_y,
  input  logic [sfa_pkg::POS_W-1:0]      in_pos_z,
  input  logic                           in_last_particle,
  input  logic [sfa_pkg::KD_W-1:0]       in_query_nx,
  input  logic [sfa_pkg::KD_W-1:0]       in_query_ny,
  input  logic [sfa_pkg::KD_W-1:0]       in_query_nz,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sfa_pkg::SF_W-1:0]       out_s_factor,
  output logic [sfa_pkg::PWR_W-1:0]      out_power_total,
  output logic [sfa_pkg::SMP_W-1:0]      out_sample_total,
  output logic                           out_no_samples,
  output logic                           out_index_invalid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0] cfg_data
);

  import sfa_pkg::*;

  item_t item;
  cfg_t  cfg;
  logic  item_valid;
  logic  item_pop;
  logic  clearing;

  sfa_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_last_particle (in_last_particle),
    .in_query_nx      (in_query_nx),
    .in_query_ny      (in_query_ny),
    .in_query_nz      (in_query_nz),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .clearing         (clearing),
    .item_pop         (item_pop),
    .item_valid       (item_valid),
    .item             (item),
    .cfg              (cfg)
  );

  sfa_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .item              (item),
    .item_valid        (item_valid),
    .item_pop          (item_pop),
    .clearing          (clearing),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_s_factor      (out_s_factor),
    .out_power_total   (out_power_total),
    .out_sample_total  (out_sample_total),
    .out_no_samples    (out_no_samples),
    .out_index_invalid (out_index_invalid)
  );

endmodule
